// ----- rtl/vlt_pkg.sv -----
// shared types, codes and helper functions for the value list table
package vlt_pkg;

	localparam int DEFAULT_CAPACITY = 64;
	localparam int WORD_W = 32;
	localparam int COUNT_OUT_W = 7;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_SUM    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_SUMZERO  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	// one finished result handed from the sequencer to the output register
	typedef struct packed {
		status_t                  status;
		logic [WORD_W-1:0]        sum;
		logic [COUNT_OUT_W-1:0]   entry_count;
	} res_t;

	// residue modulo 5 of a 32-bit word: 16 is 1 mod 5, so nibbles just add up
	function automatic logic [2:0] mod5_word(input logic [WORD_W-1:0] w);
		logic [6:0] s;
		logic [4:0] t;
		logic [4:0] u;
		logic [4:0] r;
		s = 7'(w[3:0]) + 7'(w[7:4]) + 7'(w[11:8]) + 7'(w[15:12])
			+ 7'(w[19:16]) + 7'(w[23:20]) + 7'(w[27:24]) + 7'(w[31:28]);
		t = 5'(s[6:4]) + 5'(s[3:0]);
		u = 5'(t[4]) + 5'(t[3:0]);
		if (u >= 5'd15) begin
			r = u - 5'd15;
		end else if (u >= 5'd10) begin
			r = u - 5'd10;
		end else if (u >= 5'd5) begin
			r = u - 5'd5;
		end else begin
			r = u;
		end
		return r[2:0];
	endfunction

	// positive and last decimal digit 7: odd and 2 mod 5, sign bit clear
	function automatic logic ends_in_seven(input logic [WORD_W-1:0] w);
		return !w[WORD_W-1] && w[0] && (mod5_word(w) == 3'd2);
	endfunction

endpackage

// ----- rtl/vlt_store.sv -----
// list storage: one write port, one read port with registered read data
module vlt_store #(
	parameter int CAPACITY = vlt_pkg::DEFAULT_CAPACITY,
	parameter int AW = $clog2(CAPACITY)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [vlt_pkg::WORD_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [vlt_pkg::WORD_W-1:0] rdata
);
	import vlt_pkg::*;

	logic [WORD_W-1:0] mem_q [CAPACITY];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data registered and valid in the cycle after the address
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/vlt_alu.sv -----
// shared compare and accumulate unit used on every entry read
module vlt_alu (
	input  logic [vlt_pkg::WORD_W-1:0] entry,
	input  logic [vlt_pkg::WORD_W-1:0] key,
	input  logic [vlt_pkg::WORD_W-1:0] acc,
	output logic                       match,
	output logic                       qualify,
	output logic [vlt_pkg::WORD_W-1:0] acc_next
);
	import vlt_pkg::*;

	// equality against the search key
	assign match = (entry == key);

	// digit-seven test and wrapping add
	assign qualify  = ends_in_seven(entry);
	assign acc_next = acc + entry;

endmodule

// ----- rtl/vlt_ctrl.sv -----
// sequencer: appends, and walks the entries for search, delete, shift and sum
module vlt_ctrl #(
	parameter int CAPACITY = vlt_pkg::DEFAULT_CAPACITY,
	parameter int AW = $clog2(CAPACITY),
	parameter int CW = $clog2(CAPACITY + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 operation,
	input  logic [vlt_pkg::WORD_W-1:0] value,
	output logic                       res_valid,
	input  logic                       res_free,
	output vlt_pkg::res_t              res,
	output logic                       mem_we,
	output logic [AW-1:0]              mem_waddr,
	output logic [vlt_pkg::WORD_W-1:0] mem_wdata,
	output logic [AW-1:0]              mem_raddr,
	input  logic [vlt_pkg::WORD_W-1:0] mem_rdata
);
	import vlt_pkg::*;

	state_t            state_q, state_d;
	op_t               op_q;
	logic [WORD_W-1:0] key_q;
	logic [WORD_W-1:0] acc_q;
	status_t           status_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic              pend_s1;
	logic [AW-1:0]     pidx_s1;

	logic              issue;
	logic              match;
	logic              qualify;
	logic [WORD_W-1:0] acc_next;
	logic              full;
	logic              empty;
	logic              hit;

	assign full  = (count_q >= CW'(CAPACITY));
	assign empty = (count_q == '0);
	assign mem_raddr = idx_q[AW-1:0];

	vlt_alu u_alu (
		.entry    (mem_rdata),
		.key      (key_q),
		.acc      (acc_q),
		.match    (match),
		.qualify  (qualify),
		.acc_next (acc_next)
	);

	// a returning read that equals the key ends a search or delete scan
	assign hit = pend_s1 && (op_q != OP_SUM) && match;

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		issue     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = value;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (op_t'(operation) == OP_APPEND) begin
						mem_we  = !full;
						state_d = S_DONE;
					end else if (empty) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				issue = (idx_q < count_q) && !hit;
				if (hit) begin
					state_d = (op_q == OP_SEARCH) ? S_DONE : S_SHIFT;
				end else if (!issue && !pend_s1) begin
					state_d = S_DONE;
				end
			end
			S_SHIFT: begin
				issue = (idx_q < count_q);
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = pidx_s1 - AW'(1);
					mem_wdata = mem_rdata;
				end
				if (!issue && !pend_s1) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				res_valid = res_free;
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers: fill count and read-in-flight flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= issue && (state_d == state_q);
			if (state_q == S_IDLE && in_valid && op_t'(operation) == OP_APPEND && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == S_SHIFT && state_d == S_DONE) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// operation payload, walk index and accumulator
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_q   <= idx_q + CW'(1);
			pidx_s1 <= idx_q[AW-1:0];
		end
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q  <= op_t'(operation);
					key_q <= value;
					idx_q <= '0;
					acc_q <= '0;
					if (op_t'(operation) == OP_APPEND) begin
						status_q <= full ? ST_FULL : ST_OK;
					end else begin
						status_q <= empty ? ST_EMPTY : ST_OK;
					end
				end
			end
			S_SCAN: begin
				if (pend_s1 && op_q == OP_SUM && qualify) begin
					acc_q <= acc_next;
				end
				if (hit) begin
					status_q <= ST_OK;
					idx_q    <= CW'(pidx_s1) + CW'(1);
				end else if (state_d == S_DONE) begin
					if (op_q == OP_SUM) begin
						status_q <= (acc_q == '0) ? ST_SUMZERO : ST_OK;
					end else begin
						status_q <= ST_NOTFOUND;
					end
				end
			end
			default: ;
		endcase
	end

	// finished result
	always_comb begin
		res.status      = status_q;
		res.sum         = (op_q == OP_SUM && status_q == ST_OK) ? acc_q : '0;
		res.entry_count = COUNT_OUT_W'(count_q);
	end

endmodule

// ----- rtl/value_list_table.sv -----
// value list table: bounded ordered list with append, delete, search and sum
//
// Input channel in_valid/in_ready carries operation and value. One item is
// worked on at a time; in_ready is high only while the sequencer is idle.
// Output channel out_valid/out_ready carries status, digit_seven_sum and
// entry_count, one result per item, from an output register.
// Append, and any operation on an empty list, goes straight from idle to the
// done state, whose result goes to the output register once it is free. Search and
// sum read one stored entry per cycle through the single memory read port.
// Delete scans to the first match, then moves each later entry up one place,
// one entry per cycle on the same read port and the memory write port. The
// memory port sets the figure of one entry a cycle.
// A new item is taken while the previous result still waits in the output
// register; if the receiver stalls, the next result is held in the
// sequencer until the register frees up.
// Reset empties the list at once; stored words need no clearing since only
// entries below the fill count are ever read.
module value_list_table #(
	parameter int CAPACITY = vlt_pkg::DEFAULT_CAPACITY
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          operation,
	input  logic signed [31:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic signed [31:0]  digit_seven_sum,
	output logic [6:0]          entry_count
);
	import vlt_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic              res_valid;
	logic              res_free;
	res_t              res;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	logic              out_valid_q;
	res_t              out_q;

	vlt_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.value     (WORD_W'(value)),
		.res_valid (res_valid),
		.res_free  (res_free),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	vlt_store #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register is free when empty or being drained this cycle
	assign res_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = 3'(out_q.status);
	assign digit_seven_sum = signed'(out_q.sum);
	assign entry_count     = out_q.entry_count;

endmodule
